// ===== hdl/rsi_pkg.sv =====
// Shared types and constants for the row stretch interpolator.
`default_nettype none
package rsi_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_SCALE  = 16;
  localparam int DEF_VALUE_BITS = 24;

  localparam int SCALE_BITS     = 5;
  localparam int ROW_WIDTH_BITS = 13;
  localparam int CFG_DATA_BITS  = 13;
  localparam int CFG_INDEX_BITS = 1;
  localparam int COLUMN_BITS    = 12;
  localparam int SUB_ROW_BITS   = 4;
  localparam int USER_BITS      = 2;

  localparam logic [SCALE_BITS-1:0]     SCALE_RESET     = SCALE_BITS'(2);
  localparam logic [ROW_WIDTH_BITS-1:0] ROW_WIDTH_RESET = ROW_WIDTH_BITS'(4096);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_SCALE     = 1'b0,
    CFG_ROW_WIDTH = 1'b1
  } rsi_cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } rsi_state_t;

endpackage
`default_nettype wire

// ===== hdl/row_stretch_interpolator_core.sv =====
// Top level of the row stretch interpolator: line store, sequencer, output register.
// Each accepted pixel is taken in, its column is read from the line store, and it passes
// through the shared bit-serial divider when the pixel above and this pixel
// are both valid and the previous row is stretched by more than one; then its results
// are issued as the output register frees. A new pixel is taken only in the idle state,
// once the last result of the previous one has been issued. Results of one pixel
// leave sub-row by sub-row through a single output register; interpolated values come from a
// running quotient and remainder so the divider runs once per pixel, not once per result.
`default_nettype none
module row_stretch_interpolator_core #(
  parameter int MAX_WIDTH  = rsi_pkg::DEF_MAX_WIDTH,
  parameter int MAX_SCALE  = rsi_pkg::DEF_MAX_SCALE,
  parameter int VALUE_BITS = rsi_pkg::DEF_VALUE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rsi_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rsi_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // height_value
  input  logic [((VALUE_BITS+7)/8)*8-1:0]    s_tdata,
  // value_valid, stretch_row
  input  logic [rsi_pkg::USER_BITS-1:0]      s_tuser,
  // last_row
  input  logic                               s_tlast,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // out_value, out_column, out_sub_row
  output logic [((VALUE_BITS+rsi_pkg::COLUMN_BITS+rsi_pkg::SUB_ROW_BITS+7)/8)*8-1:0] m_tdata,
  // out_valid, out_group
  output logic [rsi_pkg::USER_BITS-1:0]      m_tuser,
  // last
  output logic                               m_tlast
);

  import rsi_pkg::*;

  localparam int S_DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
  localparam int M_DATA_BITS = ((VALUE_BITS + COLUMN_BITS + SUB_ROW_BITS + 7) / 8) * 8;
  localparam int CW          = $clog2(MAX_WIDTH);
  localparam int WW          = $clog2(MAX_WIDTH + 1);
  localparam int SW          = $clog2(MAX_SCALE + 1);
  localparam int KW          = $clog2(MAX_SCALE);
  localparam int DW          = VALUE_BITS + 1;

  rsi_state_t state, state_next;

  logic [SCALE_BITS-1:0]     scale;
  logic [ROW_WIDTH_BITS-1:0] row_width;
  logic [CW-1:0]             column_count;
  logic                      prev_row_stretched;
  logic                      have_previous_row;

  logic [SW-1:0] s_eff;
  logic [WW-1:0] w_eff;
  logic [CW-1:0] col;
  logic          accept;
  logic          row_end;

  logic [VALUE_BITS:0] line_mem [MAX_WIDTH];
  logic [VALUE_BITS:0] rd_word;

  logic [VALUE_BITS-1:0] b_val;
  logic                  b_ok;
  logic                  last_q;
  logic                  hp_q;
  logic [CW-1:0]         col_q;
  logic [SW-1:0]         sp_q;
  logic [SW-1:0]         sc_q;
  logic [VALUE_BITS-1:0] a_val;
  logic                  a_ok;
  logic                  diff_neg;
  logic [DW-1:0]         q0;
  logic [SW:0]           r0;
  logic [DW-1:0]         acc_q;
  logic [SW+1:0]         acc_r;
  logic [KW-1:0]         k;
  logic                  grp;

  logic [DW-1:0] diff;
  logic [DW-1:0] mag;
  logic          need_div;
  logic          div_start;
  logic          div_done;
  logic [DW-1:0] div_quot;
  logic [SW-1:0] div_rem;

  logic          emit;
  logic          out_free;
  logic          grp_end;
  logic          res_last;
  logic [SW+1:0] rsum;
  logic          wrap;
  logic [DW-1:0] interp;
  logic [VALUE_BITS-1:0] res_value;
  logic          res_ok;

  logic [VALUE_BITS-1:0] o_value;
  logic                  o_ok;
  logic [CW-1:0]         o_col;
  logic [KW-1:0]         o_k;
  logic                  o_grp;
  logic                  o_last;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale     <= SCALE_RESET;
      row_width <= ROW_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SCALE:     scale     <= cfg_data[SCALE_BITS-1:0];
        CFG_ROW_WIDTH: row_width <= cfg_data[ROW_WIDTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (scale == '0) s_eff = SW'(1);
    else if (32'(scale) > 32'(MAX_SCALE)) s_eff = SW'(MAX_SCALE);
    else s_eff = SW'(scale);
    if (row_width == '0) w_eff = WW'(1);
    else if (32'(row_width) > 32'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(row_width);
  end

  assign col     = (WW'(column_count) >= w_eff) ? CW'(w_eff - 1'b1) : column_count;
  assign row_end = (WW'(col) + WW'(1)) >= w_eff;
  assign accept  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count       <= '0;
      prev_row_stretched <= 1'b0;
      have_previous_row  <= 1'b0;
    end else if (accept) begin
      if (row_end) begin
        column_count       <= '0;
        prev_row_stretched <= s_tuser[1];
        have_previous_row  <= !s_tlast;
      end else begin
        column_count <= col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_word       <= line_mem[col];
      line_mem[col] <= {s_tuser[0], s_tdata[VALUE_BITS-1:0]};
    end
  end

  assign diff     = {rd_word[VALUE_BITS-1], rd_word[VALUE_BITS-1:0]}
                  - {b_val[VALUE_BITS-1], b_val};
  assign mag      = diff[DW-1] ? DW'(0) - diff : diff;
  assign need_div = hp_q && (sp_q > SW'(1)) && rd_word[VALUE_BITS] && b_ok;

  rsi_divider #(
    .DIVIDEND_BITS(DW),
    .DIVISOR_BITS (SW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag),
    .divisor  (sp_q),
    .done     (div_done),
    .quotient (div_quot),
    .remainder(div_rem)
  );

  assign out_free = !m_tvalid || m_tready;
  assign grp_end  = grp ? (k == KW'(sc_q - 1'b1)) : (k == KW'(sp_q - 1'b1));
  assign res_last = grp_end && (grp || !last_q);

  // running quotient/remainder of (2*k*|b-a| + s) / (2*s)
  assign rsum   = acc_r + (SW+2)'(r0);
  assign wrap   = rsum >= (SW+2)'({sp_q, 1'b0});
  assign interp = diff_neg ? {a_val[VALUE_BITS-1], a_val} + acc_q
                           : {a_val[VALUE_BITS-1], a_val} - acc_q;

  always_comb begin
    res_value = b_val;
    res_ok    = b_ok;
    if (!grp) begin
      if (k == '0 || (a_ok && !b_ok)) begin
        res_value = a_val;
        res_ok    = a_ok;
      end else if (a_ok && b_ok) begin
        res_value = interp[VALUE_BITS-1:0];
        res_ok    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    emit       = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = !rst;
        if (s_tvalid) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (need_div) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end else if (hp_q || last_q) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          if (res_last) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_val  <= s_tdata[VALUE_BITS-1:0];
      b_ok   <= s_tuser[0];
      last_q <= s_tlast;
      hp_q   <= have_previous_row;
      col_q  <= col;
      sp_q   <= prev_row_stretched ? s_eff : SW'(1);
      sc_q   <= s_tuser[1] ? s_eff : SW'(1);
    end
    if (state == ST_LOAD) begin
      a_val    <= rd_word[VALUE_BITS-1:0];
      a_ok     <= rd_word[VALUE_BITS];
      diff_neg <= diff[DW-1];
      acc_q    <= '0;
      acc_r    <= (SW+2)'(sp_q);
      k        <= '0;
      grp      <= !hp_q;
      q0       <= '0;
      r0       <= '0;
    end
    if (div_done) begin
      q0 <= div_quot;
      r0 <= {div_rem, 1'b0};
    end
    if (emit) begin
      o_value <= res_value;
      o_ok    <= res_ok;
      o_col   <= col_q;
      o_k     <= k;
      o_grp   <= grp;
      o_last  <= res_last;
      if (!grp) begin
        acc_r <= wrap ? rsum - (SW+2)'({sp_q, 1'b0}) : rsum;
        acc_q <= acc_q + q0 + DW'(wrap);
      end
      if (grp_end) begin
        grp <= 1'b1;
        k   <= '0;
      end else begin
        k <= k + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (emit) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  assign m_tdata = M_DATA_BITS'({SUB_ROW_BITS'(o_k), COLUMN_BITS'(o_col), o_value});
  assign m_tuser = {o_grp, o_ok};
  assign m_tlast = o_last;

  logic unused_s_tdata;
  assign unused_s_tdata = ^s_tdata[S_DATA_BITS-1:VALUE_BITS-1];

endmodule
`default_nettype wire

// ===== hdl/rsi_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module rsi_divider #(
  parameter int DIVIDEND_BITS = 25,
  parameter int DIVISOR_BITS  = 5
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [DIVISOR_BITS-1:0]  divisor,
  output logic                     done,
  output logic [DIVIDEND_BITS-1:0] quotient,
  output logic [DIVISOR_BITS-1:0]  remainder
);

  localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

  logic                     busy;
  logic [CNT_BITS-1:0]      count;
  logic [DIVIDEND_BITS-1:0] quot;
  logic [DIVISOR_BITS-1:0]  rem;
  logic [DIVISOR_BITS-1:0]  dvs;
  logic [DIVISOR_BITS:0]    trial;
  logic                     fits;

  assign trial = {rem, quot[DIVIDEND_BITS-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_BITS'(DIVIDEND_BITS);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      quot <= {quot[DIVIDEND_BITS-2:0], fits};
      rem  <= fits ? DIVISOR_BITS'(trial - {1'b0, dvs}) : trial[DIVISOR_BITS-1:0];
    end
  end

  assign quotient  = quot;
  assign remainder = rem;

endmodule
`default_nettype wire

// ===== hdl/rsi_checker.sv =====
// Port-level checks for the row stretch interpolator, bound to the top level.
`default_nettype none
module rsi_checker #(
  parameter int DATA_BITS = 40
) (
  input wire                 clk,
  input wire                 rst,
  input wire                 s_tvalid,
  input wire                 s_tready,
  input wire                 m_tvalid,
  input wire                 m_tready,
  input wire [DATA_BITS-1:0] m_tdata,
  input wire                 m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output transaction changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken on back-to-back cycles");

  a_no_take_mid_burst: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input ready before all results of a pixel left");

endmodule

bind row_stretch_interpolator_core rsi_checker #(
  .DATA_BITS(M_DATA_BITS)
) u_rsi_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast)
);
`default_nettype wire
